// ----- src/rls_pkg.sv -----
// ----------------------------------------------------------------------------
// rls_pkg: shared types and helpers of the line-fit estimator
// Sequencer codes, handshake structs of the shared multiply/divide unit and
// the saturating fit helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rls_pkg;

   localparam int VALUE_WIDTH_DEF   = 64;
   localparam int COV_FRAC_BITS_DEF = 56;

   // Reset values of the configuration registers
   localparam logic [31:0] LAMBDA_ONE        = 32'h8000_0000;
   localparam logic [62:0] VAR_SLOPE_RST     = 63'd7205759;
   localparam logic [62:0] VAR_INTERCEPT_RST = 63'd7205759403792794;

   // Configuration register indexes
   localparam logic [2:0] CSR_LAMBDA     = 3'd0;
   localparam logic [2:0] CSR_SLOPE      = 3'd1;
   localparam logic [2:0] CSR_INTERCEPT  = 3'd2;
   localparam logic [2:0] CSR_VAR_SLOPE  = 3'd3;
   localparam logic [2:0] CSR_VAR_ICPT   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ISSUE, ST_WAIT, ST_POST, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_K0, OP_K1, OP_EST, OP_ERR, OP_DEN, OP_DEN2, OP_DEN3,
      OP_SL, OP_IC, OP_NA, OP_NC, OP_ND, OP_CA, OP_CC, OP_CI
   } op_type;

   typedef enum logic [2:0] {
      MD_IDLE, MD_MUL, MD_ROUND, MD_DIV, MD_FIN
   } md_phase_type;

   // Command to the multiply/divide unit
   typedef struct packed {
      logic start;
      logic use_shift;   // divisor is 2^32: round and shift
      logic wide;        // saturate to 64 bits, else to the value width
   } md_req_type;

   // Status from the multiply/divide unit
   typedef struct packed {
      logic done;
      logic clip;
   } md_rsp_type;

   // Clamp an exact 65-bit sum to a signed w-bit range: {clip, value}
   function automatic logic [64:0] rls_fit(input logic [64:0] sum, input int w);
      logic signed [64:0] s;
      logic signed [64:0] hi;
      logic signed [64:0] lo;
      logic [64:0]        res;
      s  = $signed(sum);
      hi = $signed({1'b0, 64'h7FFF_FFFF_FFFF_FFFF >> (64 - w)});
      lo = -hi - 65'sd1;
      if (s > hi) begin
         res = {1'b1, hi[63:0]};
      end else if (s < lo) begin
         res = {1'b1, lo[63:0]};
      end else begin
         res = {1'b0, s[63:0]};
      end
      return res;
   endfunction

endpackage

// ----- src/rls_muldiv.sv -----
// ----------------------------------------------------------------------------
// rls_muldiv: shared multiply, round and divide unit
// Forms round(p*q/den) on the exact 128-bit product with a 32x32 multiplier
// and a restoring divider at one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rls_muldiv #(
   parameter int VALUE_WIDTH = rls_pkg::VALUE_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rls_pkg::md_req_type  md_req,
   input  logic [63:0]          op_p,
   input  logic [63:0]          op_q,
   input  logic [63:0]          op_den,
   output logic [63:0]          md_result,
   output rls_pkg::md_rsp_type  md_rsp
);
   import rls_pkg::*;

   md_phase_type  phase_ff, phase_in;
   logic [6:0]    cnt_ff;
   logic [63:0]   mp_ff, mq_ff, den_ff;
   logic          neg_ff, shift_ff, wide_ff;
   logic [127:0]  acc_ff;
   logic [63:0]   rem_ff, quo_ff;
   logic          ovf_ff;

   logic [31:0]   mul_a, mul_b;
   logic [63:0]   pp;
   logic [127:0]  pp_wide;
   logic [127:0]  rnd_sum;
   logic [64:0]   r2;
   logic          ge;
   logic [64:0]   r2_sub;
   logic [63:0]   lim;
   logic          fin_clip;
   logic [63:0]   qf;
   int            w_eff;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         MD_IDLE:  if (md_req.start) phase_in = MD_MUL;
         MD_MUL:   if (cnt_ff[1:0] == 2'd3) phase_in = MD_ROUND;
         MD_ROUND: phase_in = shift_ff ? MD_FIN : MD_DIV;
         MD_DIV:   if (cnt_ff == 7'd127) phase_in = MD_FIN;
         MD_FIN:   phase_in = MD_IDLE;
         default:  phase_in = MD_IDLE;
      endcase
   end

   // Partial product of one pair of 32-bit halves
   always_comb begin
      mul_a = cnt_ff[0] ? mp_ff[63:32] : mp_ff[31:0];
      mul_b = cnt_ff[1] ? mq_ff[63:32] : mq_ff[31:0];
      pp    = mul_a * mul_b;
      case ({1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]})
         2'd0:    pp_wide = {64'd0, pp};
         2'd1:    pp_wide = {32'd0, pp, 32'd0};
         2'd2:    pp_wide = {pp, 64'd0};
         default: pp_wide = 128'd0;
      endcase
   end

   // Rounding offset and one restoring divide step
   always_comb begin
      rnd_sum = acc_ff + (shift_ff ? 128'h8000_0000 : {64'd0, 1'b0, den_ff[63:1]});
      r2      = {rem_ff, acc_ff[127]};
      r2_sub  = r2 - {1'b0, den_ff};
      ge      = (r2 >= {1'b0, den_ff});
   end

   // Saturate the quotient and apply the sign
   always_comb begin
      w_eff     = wide_ff ? 64 : VALUE_WIDTH;
      lim       = (64'h7FFF_FFFF_FFFF_FFFF >> (64 - w_eff)) + {63'd0, neg_ff};
      fin_clip  = ovf_ff || (quo_ff > lim);
      qf        = fin_clip ? lim : quo_ff;
      md_result = neg_ff ? (~qf + 64'd1) : qf;
      md_rsp.done = (phase_ff == MD_FIN);
      md_rsp.clip = (phase_ff == MD_FIN) && fin_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MD_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (phase_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               mp_ff    <= op_p[63] ? (~op_p + 64'd1) : op_p;
               mq_ff    <= op_q[63] ? (~op_q + 64'd1) : op_q;
               neg_ff   <= op_p[63] ^ op_q[63];
               den_ff   <= op_den;
               shift_ff <= md_req.use_shift;
               wide_ff  <= md_req.wide;
               acc_ff   <= 128'd0;
               cnt_ff   <= 7'd0;
            end
         end
         MD_MUL: begin
            acc_ff <= acc_ff + pp_wide;
            cnt_ff <= cnt_ff + 7'd1;
         end
         MD_ROUND: begin
            cnt_ff <= 7'd0;
            rem_ff <= 64'd0;
            if (shift_ff) begin
               quo_ff <= rnd_sum[95:32];
               ovf_ff <= |rnd_sum[127:96];
            end else begin
               acc_ff <= rnd_sum;
               quo_ff <= 64'd0;
               ovf_ff <= 1'b0;
            end
         end
         MD_DIV: begin
            rem_ff <= ge ? r2_sub[63:0] : r2[63:0];
            acc_ff <= {acc_ff[126:0], 1'b0};
            quo_ff <= {quo_ff[62:0], ge};
            ovf_ff <= ovf_ff | quo_ff[63];
            cnt_ff <= cnt_ff + 7'd1;
         end
         default: begin
         end
      endcase
   end

   // A new operation starts only when the unit is free
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      md_req.start |-> phase_ff == MD_IDLE)
      else $error("multiply/divide started while busy");

   // Partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == MD_DIV |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

   // Finish follows rounding or the last divide step
   a_fin_order: assert property (@(posedge clock) disable iff (reset)
      phase_ff == MD_FIN |-> $past(phase_ff) == MD_ROUND || $past(phase_ff) == MD_DIV)
      else $error("finish out of order");

endmodule

// ----- src/rls_line_fit_estimator.sv -----
// ----------------------------------------------------------------------------
// rls_line_fit_estimator: recursive least squares line fit
// Fits y = slope*x + intercept with a forgetting factor, keeping a 2x2
// covariance; a small sequencer drives one shared multiply/divide unit.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / data                      | tuser / index
//  req_    | in        | [63:0] x_measure, [127:64] y      | req_type
//  rsp_    | out       | slope, intercept, prediction_error| saturated
//  csr_    | in        | csr_data: register value          | csr_index
//
//  A restart goes from the accept step straight to the output step. A measurement
//  runs 15 sequencer steps: four products divided by 2^32, eight rounded
//  divisions in the one-bit-per-cycle divider and three plain add or compare
//  steps, framed by the accept and output steps. req_tready is high only when idle.
//  A finished result waits in the output register while rsp_tready is low;
//  the next item is taken meanwhile. Reset loads the default state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rls_line_fit_estimator #(
   parameter int VALUE_WIDTH   = rls_pkg::VALUE_WIDTH_DEF,
   parameter int COV_FRAC_BITS = rls_pkg::COV_FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // x_measure[63:0], y_measure[127:64]
   input  logic          req_tuser,   // req_type
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [191:0]  rsp_tdata,   // slope_out, intercept_out, prediction_error
   output logic          rsp_tuser,   // saturated
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_data
);
   import rls_pkg::*;

   // Default covariance diagonal in the configured fraction format
   localparam logic [63:0] COV_ONE = 64'd1 << COV_FRAC_BITS;
   localparam logic [62:0] VAR_SLOPE_INIT =
      63'((COV_ONE + 64'd5000000000) / 64'd10000000000);
   localparam logic [62:0] VAR_ICPT_INIT = 63'((COV_ONE + 64'd5) / 64'd10);

   state_type   state_ff, state_in;
   op_type      op_ff;

   logic [31:0] cfg_lambda_ff;
   logic [63:0] cfg_slope_ff, cfg_icpt_ff;
   logic [62:0] cfg_var_slope_ff, cfg_var_icpt_ff;

   logic [63:0] slope_ff, icpt_ff, cs_ff, cc_ff, ci_ff;
   logic [63:0] x_ff, y_ff, k0_ff, k1_ff, est_ff, err_ff, deno_ff;
   logic [63:0] na_ff, nc_ff, nd_ff, t_ff;
   logic [31:0] lam_ff;
   logic        sat_ff;
   logic        rsp_valid_ff;
   logic [191:0] rsp_data_ff;
   logic        rsp_sat_ff;

   logic        req_accept, out_free, uses_md;
   md_req_type  md_req;
   md_rsp_type  md_rsp;
   logic [63:0] md_p, md_q, md_den, md_result;
   logic [64:0] fit_x, fit_y, fit_s, fit_i;
   logic [31:0] lam_in;
   logic [63:0] lam_cov;
   logic [63:0] post_a, post_b;
   logic        post_sub, post_wide;
   logic [64:0] post_sum, post_fit;
   logic        deno_low;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign lam_cov    = {32'd0, lam_ff} << (COV_FRAC_BITS - 31);
   assign deno_low   = $signed(deno_ff) < $signed(lam_cov);

   // Clamp the inputs, loaded values and lambda
   always_comb begin
      fit_x = rls_fit({req_tdata[63], req_tdata[63:0]}, VALUE_WIDTH);
      fit_y = rls_fit({req_tdata[127], req_tdata[127:64]}, VALUE_WIDTH);
      fit_s = rls_fit({cfg_slope_ff[63], cfg_slope_ff}, VALUE_WIDTH);
      fit_i = rls_fit({cfg_icpt_ff[63], cfg_icpt_ff}, VALUE_WIDTH);
      if (cfg_lambda_ff == 32'd0) begin
         lam_in = 32'd1;
      end else if (cfg_lambda_ff > LAMBDA_ONE) begin
         lam_in = LAMBDA_ONE;
      end else begin
         lam_in = cfg_lambda_ff;
      end
   end

   // Operands of the shared unit for each step
   always_comb begin
      uses_md = 1'b1;
      md_p    = x_ff;
      md_q    = x_ff;
      md_den  = deno_ff;
      md_req.use_shift = 1'b0;
      md_req.wide      = 1'b1;
      case (op_ff)
         OP_K0:  begin md_p = cs_ff;    md_req.use_shift = 1'b1; end
         OP_K1:  begin md_p = cc_ff;    md_req.use_shift = 1'b1; end
         OP_EST: begin
            md_p = slope_ff; md_req.use_shift = 1'b1; md_req.wide = 1'b0;
         end
         OP_DEN: begin md_p = k0_ff;    md_req.use_shift = 1'b1; end
         OP_SL:  begin md_p = err_ff; md_q = k0_ff; md_req.wide = 1'b0; end
         OP_IC:  begin md_p = err_ff; md_q = k1_ff; md_req.wide = 1'b0; end
         OP_NA:  begin md_p = k0_ff;  md_q = k0_ff; end
         OP_NC:  begin md_p = k0_ff;  md_q = k1_ff; end
         OP_ND:  begin md_p = k1_ff;  md_q = k1_ff; end
         OP_CA:  begin md_p = na_ff; md_q = {32'd0, LAMBDA_ONE}; md_den = {32'd0, lam_ff}; end
         OP_CC:  begin md_p = nc_ff; md_q = {32'd0, LAMBDA_ONE}; md_den = {32'd0, lam_ff}; end
         OP_CI:  begin md_p = nd_ff; md_q = {32'd0, LAMBDA_ONE}; md_den = {32'd0, lam_ff}; end
         default: uses_md = 1'b0;
      endcase
      md_req.start = (state_ff == ST_ISSUE) && uses_md;
   end

   // Saturating add or subtract after each step
   always_comb begin
      post_a    = t_ff;
      post_b    = 64'd0;
      post_sub  = 1'b0;
      post_wide = 1'b1;
      case (op_ff)
         OP_K0:   post_b = cc_ff;
         OP_K1:   post_b = ci_ff;
         OP_EST:  begin post_b = icpt_ff; post_wide = 1'b0; end
         OP_ERR:  begin post_a = y_ff; post_b = est_ff; post_sub = 1'b1; post_wide = 1'b0; end
         OP_DEN:  post_b = lam_cov;
         OP_DEN2: begin post_a = deno_ff; post_b = k1_ff; end
         OP_SL:   begin post_a = slope_ff; post_wide = 1'b0; end
         OP_IC:   begin post_a = icpt_ff; post_wide = 1'b0; end
         OP_NA:   begin post_a = cs_ff; post_b = t_ff; post_sub = 1'b1; end
         OP_NC:   begin post_a = cc_ff; post_b = t_ff; post_sub = 1'b1; end
         OP_ND:   begin post_a = ci_ff; post_b = t_ff; post_sub = 1'b1; end
         default: post_b = 64'd0;
      endcase
      if (op_ff == OP_SL || op_ff == OP_IC) begin
         post_b = t_ff;
      end
      post_sum = post_sub ? ({post_a[63], post_a} - {post_b[63], post_b})
                          : ({post_a[63], post_a} + {post_b[63], post_b});
      post_fit = rls_fit(post_sum, post_wide ? 64 : VALUE_WIDTH);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_accept) state_in = req_tuser ? ST_OUT : ST_ISSUE;
         ST_ISSUE: state_in = uses_md ? ST_WAIT : ST_POST;
         ST_WAIT:  if (md_rsp.done) state_in = ST_POST;
         ST_POST:  state_in = (op_ff == OP_CI) ? ST_OUT : ST_ISSUE;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;
      rsp_tuser  = rsp_sat_ff;
   end

   rls_muldiv #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .md_req    (md_req),
      .op_p      (md_p),
      .op_q      (md_q),
      .op_den    (md_den),
      .md_result (md_result),
      .md_rsp    (md_rsp)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_lambda_ff    <= LAMBDA_ONE;
         cfg_slope_ff     <= 64'd0;
         cfg_icpt_ff      <= 64'd0;
         cfg_var_slope_ff <= VAR_SLOPE_INIT;
         cfg_var_icpt_ff  <= VAR_ICPT_INIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LAMBDA:    cfg_lambda_ff    <= csr_data[31:0];
            CSR_SLOPE:     cfg_slope_ff     <= csr_data;
            CSR_INTERCEPT: cfg_icpt_ff      <= csr_data;
            CSR_VAR_SLOPE: cfg_var_slope_ff <= csr_data[62:0];
            CSR_VAR_ICPT:  cfg_var_icpt_ff  <= csr_data[62:0];
            default: begin
            end
         endcase
      end
   end

   // Estimator state
   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff <= 64'd0;
         icpt_ff  <= 64'd0;
         cs_ff    <= {1'b0, VAR_SLOPE_INIT};
         cc_ff    <= 64'd0;
         ci_ff    <= {1'b0, VAR_ICPT_INIT};
      end else if (state_ff == ST_IDLE && req_accept && req_tuser) begin
         slope_ff <= fit_s[63:0];
         icpt_ff  <= fit_i[63:0];
         cs_ff    <= {1'b0, cfg_var_slope_ff};
         cc_ff    <= 64'd0;
         ci_ff    <= {1'b0, cfg_var_icpt_ff};
      end else if (state_ff == ST_POST) begin
         case (op_ff)
            OP_SL:   slope_ff <= post_fit[63:0];
            OP_IC:   icpt_ff  <= post_fit[63:0];
            OP_CA:   cs_ff    <= t_ff;
            OP_CC:   cc_ff    <= t_ff;
            OP_CI:   ci_ff    <= t_ff;
            default: begin
            end
         endcase
      end
   end

   // Working registers of one measurement
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_ff  <= OP_K0;
               x_ff   <= fit_x[63:0];
               y_ff   <= fit_y[63:0];
               lam_ff <= lam_in;
               err_ff <= 64'd0;
               sat_ff <= req_tuser ? (fit_s[64] | fit_i[64]) : (fit_x[64] | fit_y[64]);
            end
         end
         ST_WAIT: begin
            if (md_rsp.done) begin
               t_ff   <= md_result;
               sat_ff <= sat_ff | md_rsp.clip;
            end
         end
         ST_POST: begin
            if (op_ff != OP_CI) begin
               op_ff <= op_type'(op_ff + 4'd1);
            end
            case (op_ff)
               OP_K0:   k0_ff   <= post_fit[63:0];
               OP_K1:   k1_ff   <= post_fit[63:0];
               OP_EST:  est_ff  <= post_fit[63:0];
               OP_ERR:  err_ff  <= post_fit[63:0];
               OP_DEN:  deno_ff <= post_fit[63:0];
               OP_DEN2: deno_ff <= post_fit[63:0];
               OP_NA:   na_ff   <= post_fit[63:0];
               OP_NC:   nc_ff   <= post_fit[63:0];
               OP_ND:   nd_ff   <= post_fit[63:0];
               default: begin
               end
            endcase
            if (op_ff == OP_DEN3) begin
               if (deno_low) begin
                  deno_ff <= lam_cov;
               end
               sat_ff <= sat_ff | deno_low;
            end else if (op_ff != OP_CA && op_ff != OP_CC && op_ff != OP_CI) begin
               sat_ff <= sat_ff | post_fit[64];
            end
         end
         default: begin
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= {err_ff, icpt_ff, slope_ff};
         rsp_sat_ff  <= sat_ff;
      end
   end

   // The shared unit reports only while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> state_ff == ST_WAIT)
      else $error("multiply/divide result outside wait");

   // Divisions by the denominator see at least lambda
   a_deno_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE && (op_ff == OP_SL || op_ff == OP_NA))
         |-> $signed(deno_ff) >= $signed(lam_cov))
      else $error("denominator below lambda");

   // A result becomes valid only from the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output step");

endmodule
